// ===== hw/rtl/stw_pkg.sv =====
// shared types, register codes and angle helpers for the sailing tack decision block
package stw_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register index, taken from byte address bits [3:2]
   typedef enum logic [1:0] {
      REG_MIN_UPWIND      = 2'd0,
      REG_MIN_DOWNWIND    = 2'd1,
      REG_SAILABLE_MARGIN = 2'd2
   } reg_index_type;

   localparam logic [7:0] UPWIND_RESET   = 8'd45;
   localparam logic [7:0] DOWNWIND_RESET = 8'd30;
   localparam logic [6:0] MARGIN_RESET   = 7'd10;

   typedef enum logic [2:0] {
      TACK_DIRECT   = 3'd0,
      TACK_PORT     = 3'd1,
      TACK_STBD     = 3'd2,
      TACK_PORT_RUN = 3'd3,
      TACK_STBD_RUN = 3'd4
   } tack_type;

   typedef enum logic [1:0] {
      GYBE_NONE    = 2'd0,
      GYBE_TO_STBD = 2'd1,
      GYBE_TO_PORT = 2'd2
   } gybe_type;

   // wide enough for any unwrapped course sum
   typedef logic signed [11:0] raw_angle_type;

   localparam raw_angle_type HALF_TURN = 12'sd180;
   localparam raw_angle_type FULL_TURN = 12'sd360;
   localparam raw_angle_type TWO_TURNS = 12'sd720;
   localparam logic [8:0]    BEAT_LIMIT = 9'd90;
   localparam logic signed [9:0] HALF_TURN_10 = 10'sd180;

   typedef struct packed {
      logic [8:0]         bearing_to_waypoint;
      logic signed [8:0]  track_correction;
      logic signed [15:0] cross_track_error;
      logic [14:0]        max_cross_track;
      logic [8:0]         heading;
      logic signed [8:0]  apparent_wind_angle;
      logic signed [8:0]  wind_angle_to_waypoint;
      logic               boundary_hold;
      logic               new_mission_step;
   } req_payload_type;

   typedef struct packed {
      logic [8:0] course_to_steer;
      tack_type   course_kind;
      gybe_type   gybe_start;
      logic       took_favoured;
      logic       boundary_switch;
   } rsp_payload_type;

   // reduce a sum in -720..1079 to 0..359
   function automatic logic [8:0] wrap_course(input raw_angle_type a);
      raw_angle_type r;
      if (a < -FULL_TURN)
         r = a + TWO_TURNS;
      else if (a < 12'sd0)
         r = a + FULL_TURN;
      else if (a >= TWO_TURNS)
         r = a - TWO_TURNS;
      else if (a >= FULL_TURN)
         r = a - FULL_TURN;
      else
         r = a;
      return r[8:0];
   endfunction

endpackage

// ===== hw/rtl/stw_req_if.sv =====
// navigation update and decision channels of the sailing tack decision block
interface stw_req_if import stw_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [8:0]         bearing_to_waypoint;
   logic signed [8:0]  track_correction;
   logic signed [15:0] cross_track_error;
   logic [14:0]        max_cross_track;
   logic [8:0]         heading;
   logic signed [8:0]  apparent_wind_angle;
   logic signed [8:0]  wind_angle_to_waypoint;
   logic               boundary_hold;
   logic               new_mission_step;

   modport source (
      output valid, bearing_to_waypoint, track_correction, cross_track_error,
             max_cross_track, heading, apparent_wind_angle, wind_angle_to_waypoint,
             boundary_hold, new_mission_step,
      input  ready
   );
   modport sink (
      input  valid, bearing_to_waypoint, track_correction, cross_track_error,
             max_cross_track, heading, apparent_wind_angle, wind_angle_to_waypoint,
             boundary_hold, new_mission_step,
      output ready
   );
endinterface

interface stw_rsp_if import stw_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [8:0] course_to_steer;
   logic [2:0] course_kind;
   logic [1:0] gybe_start;
   logic       took_favoured;
   logic       boundary_switch;

   modport source (
      output valid, course_to_steer, course_kind, gybe_start, took_favoured,
             boundary_switch,
      input  ready
   );
   modport sink (
      input  valid, course_to_steer, course_kind, gybe_start, took_favoured,
             boundary_switch,
      output ready
   );
endinterface

// ===== hw/rtl/sailing_tack_decision.sv =====
// top level of the sailing tack decision block
//
//  channel      | dir | handshake               | content
//  -------------+-----+-------------------------+--------------------------------
//  req_chan     | in  | valid/ready             | one navigation update
//  rsp_chan     | out | valid/ready             | course, tack kind, gybe, flags
//  csr_*        | in  | apb, pready tied high   | upwind, downwind, margin limits
//
//  one transaction per clock sustained while the result side is ready; an update
//  passes the input register, then the result register, decision logic in between
//  the tack register updates when an update moves into the result register,
//  so the next update always sees the tack its predecessor left
//  reset (synchronous, active high) empties both stages, sets the tack to
//  direct and loads the default angle limits
//  a stalled result holds the result register; the input register keeps
//  accepting until it is full as well
module sailing_tack_decision import stw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   stw_req_if.sink               req_chan,
   stw_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // configuration registers
   logic [7:0] min_upwind_ff;
   logic [7:0] min_downwind_ff;
   logic [6:0] margin_ff;
   logic       csr_write;

   // pipeline control
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   tack_type        tack_state_ff, tack_state_in;
   logic            req_accept, rsp_free, advance;

   // decision datapath
   logic signed [16:0] cte_ext, cte_neg, maxc_ext;
   logic               over_stbd, over_port, off_track;
   logic [6:0]         margin_eff;
   logic [8:0]         awtw;
   logic [8:0]         up_limit;
   logic signed [9:0]  down_limit;
   logic               sailable, go_direct;
   tack_type           fav_tack, pick_tack, next_tack;
   logic               take_fav;
   gybe_type           gybe;
   logic               swapped;
   raw_angle_type      hdg_awa, up_s, down_s, course_raw;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_upwind_ff   <= UPWIND_RESET;
         min_downwind_ff <= DOWNWIND_RESET;
         margin_ff       <= MARGIN_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_MIN_UPWIND:      min_upwind_ff   <= csr_pwdata[7:0];
            REG_MIN_DOWNWIND:    min_downwind_ff <= csr_pwdata[7:0];
            REG_SAILABLE_MARGIN: margin_ff       <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_MIN_UPWIND:      csr_prdata = {24'd0, min_upwind_ff};
         REG_MIN_DOWNWIND:    csr_prdata = {24'd0, min_downwind_ff};
         REG_SAILABLE_MARGIN: csr_prdata = {25'd0, margin_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   // the result register frees when empty or taken this cycle
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || rsp_free;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept)
         s1_valid_in = 1'b1;
      else if (advance)
         s1_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance)
         rsp_valid_in = 1'b1;
      else if (rsp_chan.ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tack_state_ff <= TACK_DIRECT;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance)
            tack_state_ff <= tack_state_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff.bearing_to_waypoint    <= req_chan.bearing_to_waypoint;
         s1_data_ff.track_correction       <= req_chan.track_correction;
         s1_data_ff.cross_track_error      <= req_chan.cross_track_error;
         s1_data_ff.max_cross_track        <= req_chan.max_cross_track;
         s1_data_ff.heading                <= req_chan.heading;
         s1_data_ff.apparent_wind_angle    <= req_chan.apparent_wind_angle;
         s1_data_ff.wind_angle_to_waypoint <= req_chan.wind_angle_to_waypoint;
         s1_data_ff.boundary_hold          <= req_chan.boundary_hold;
         s1_data_ff.new_mission_step       <= req_chan.new_mission_step;
      end
   end

   // ---------------------------------------------------------------- decision
   always_comb begin
      // boundary tests on the cross-track error, one side each
      cte_ext   = 17'(s1_data_ff.cross_track_error);
      cte_neg   = -cte_ext;
      maxc_ext  = signed'({2'b00, s1_data_ff.max_cross_track});
      over_stbd = cte_ext > maxc_ext;
      over_port = cte_neg > maxc_ext;
      off_track = over_stbd || over_port;

      // margin is halved outside the boundary
      margin_eff = off_track ? (margin_ff >> 1) : margin_ff;

      awtw = s1_data_ff.wind_angle_to_waypoint[8]
             ? 9'(-s1_data_ff.wind_angle_to_waypoint)
             : 9'(s1_data_ff.wind_angle_to_waypoint);

      up_limit   = {1'b0, min_upwind_ff} + {2'b00, margin_eff};
      down_limit = HALF_TURN_10 - signed'({2'b00, min_downwind_ff});
      sailable   = (awtw >= up_limit) && (signed'({1'b0, awtw}) <= down_limit);
      go_direct  = sailable && !s1_data_ff.boundary_hold;

      // favoured tack from the side and size of the wind angle
      if (s1_data_ff.wind_angle_to_waypoint <= 9'sd0)
         fav_tack = (awtw <= BEAT_LIMIT) ? TACK_PORT : TACK_PORT_RUN;
      else
         fav_tack = (awtw <= BEAT_LIMIT) ? TACK_STBD : TACK_STBD_RUN;

      // unused tack codes count as direct
      take_fav  = (tack_state_ff == TACK_DIRECT) || (tack_state_ff > TACK_STBD_RUN)
                  || s1_data_ff.new_mission_step;
      pick_tack = take_fav ? fav_tack : tack_state_ff;

      // swap at the boundary on the side the tack heads for
      next_tack = pick_tack;
      gybe      = GYBE_NONE;
      swapped   = 1'b0;
      unique case (pick_tack)
         TACK_PORT: begin
            if (over_stbd) begin
               next_tack = TACK_STBD;
               gybe      = GYBE_TO_STBD;
               swapped   = 1'b1;
            end
         end
         TACK_STBD: begin
            if (over_port) begin
               next_tack = TACK_PORT;
               gybe      = GYBE_TO_PORT;
               swapped   = 1'b1;
            end
         end
         TACK_PORT_RUN: begin
            if (over_port) begin
               next_tack = TACK_STBD_RUN;
               swapped   = 1'b1;
            end
         end
         default: begin
            if (over_stbd) begin
               next_tack = TACK_PORT_RUN;
               swapped   = 1'b1;
            end
         end
      endcase

      // unwrapped course for the chosen branch
      hdg_awa = raw_angle_type'({3'b000, s1_data_ff.heading})
                + raw_angle_type'(s1_data_ff.apparent_wind_angle);
      up_s    = raw_angle_type'({4'b0000, min_upwind_ff});
      down_s  = raw_angle_type'({4'b0000, min_downwind_ff});

      if (go_direct) begin
         course_raw = raw_angle_type'({3'b000, s1_data_ff.bearing_to_waypoint})
                      - raw_angle_type'(s1_data_ff.track_correction);
      end else begin
         unique case (next_tack)
            TACK_PORT:     course_raw = hdg_awa + up_s;
            TACK_STBD:     course_raw = hdg_awa - up_s;
            TACK_PORT_RUN: course_raw = hdg_awa - down_s + HALF_TURN;
            default:       course_raw = hdg_awa + down_s - HALF_TURN;
         endcase
      end

      tack_state_in = go_direct ? TACK_DIRECT : next_tack;

      rsp_data_in.course_to_steer = wrap_course(course_raw);
      rsp_data_in.course_kind     = tack_state_in;
      rsp_data_in.gybe_start      = go_direct ? GYBE_NONE : gybe;
      rsp_data_in.took_favoured   = !go_direct && take_fav;
      rsp_data_in.boundary_switch = !go_direct && swapped;
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.course_to_steer = rsp_data_ff.course_to_steer;
   assign rsp_chan.course_kind     = rsp_data_ff.course_kind;
   assign rsp_chan.gybe_start      = rsp_data_ff.gybe_start;
   assign rsp_chan.took_favoured   = rsp_data_ff.took_favoured;
   assign rsp_chan.boundary_switch = rsp_data_ff.boundary_switch;

endmodule

// ===== hw/rtl/stw_checker.sv =====
// port-level assertions for the sailing tack decision block, with bind
module stw_checker import stw_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [8:0] course_to_steer,
   input logic [2:0] course_kind,
   input logic [1:0] gybe_start,
   input logic       took_favoured,
   input logic       boundary_switch
);

   // a stalled result stays and holds its course
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(course_to_steer))
      else $error("stalled result changed");

   a_course_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> course_to_steer < 9'd360)
      else $error("course out of 0..359");

   // direct course carries no tack flags
   a_direct_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && course_kind == TACK_DIRECT |->
         gybe_start == GYBE_NONE && !took_favoured && !boundary_switch)
      else $error("flags set on direct course");

   // a gybe start comes only with a boundary swap onto a beating tack
   a_gybe_swap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && gybe_start != GYBE_NONE |-> boundary_switch &&
         ((gybe_start == GYBE_TO_STBD && course_kind == TACK_STBD) ||
          (gybe_start == GYBE_TO_PORT && course_kind == TACK_PORT)))
      else $error("gybe start without matching swap");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sailing_tack_decision stw_checker u_stw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .course_to_steer (rsp_chan.course_to_steer),
   .course_kind     (rsp_chan.course_kind),
   .gybe_start      (rsp_chan.gybe_start),
   .took_favoured   (rsp_chan.took_favoured),
   .boundary_switch (rsp_chan.boundary_switch)
);

// ===== tb/tb_top.sv =====
// self-checking testbench for the sailing tack decision block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import stw_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_UPDATES  = 240;

   // tracks the tack register and limits, and holds the decisions still owed by the block
   class course_checker;
      int              up_lim;
      int              down_lim;
      int              margin_lim;
      tack_type        tack;
      rsp_payload_type pending_decisions[$];
      int              errors;

      function new();
         up_lim     = UPWIND_RESET;
         down_lim   = DOWNWIND_RESET;
         margin_lim = MARGIN_RESET;
         tack       = TACK_DIRECT;
         errors     = 0;
      endfunction

      // decision for one navigation update, advancing the tack register
      function rsp_payload_type decide(req_payload_type u);
         int  bear, corr, cte, maxc, hdg, awa, wta;
         int  abs_wta, abs_cte, marg, raw, deg;
         bit  sailable;
         rsp_payload_type d;
         bear    = u.bearing_to_waypoint;
         corr    = $signed(u.track_correction);
         cte     = $signed(u.cross_track_error);
         maxc    = u.max_cross_track;
         hdg     = u.heading;
         awa     = $signed(u.apparent_wind_angle);
         wta     = $signed(u.wind_angle_to_waypoint);
         abs_wta = (wta < 0) ? -wta : wta;
         abs_cte = (cte < 0) ? -cte : cte;
         d       = '0;

         // margin is halved once the boat is outside the cross-track boundary
         marg = margin_lim;
         if (abs_cte > maxc)
            marg = marg / 2;
         sailable = (abs_wta >= up_lim + marg) && (abs_wta <= 180 - down_lim);

         if (sailable && !u.boundary_hold) begin
            raw  = bear - corr;
            tack = TACK_DIRECT;
         end else begin
            // coming from direct sailing or a fresh mission step: take the favoured tack
            if (tack == TACK_DIRECT || u.new_mission_step) begin
               if (wta <= 0)
                  tack = (abs_wta <= 90) ? TACK_PORT : TACK_PORT_RUN;
               else
                  tack = (abs_wta <= 90) ? TACK_STBD : TACK_STBD_RUN;
               d.took_favoured = 1'b1;
            end
            // boundary swaps, checked on the tack just chosen or kept
            case (tack)
               TACK_PORT: begin
                  if (cte > maxc) begin
                     tack = TACK_STBD;
                     d.gybe_start = GYBE_TO_STBD;
                     d.boundary_switch = 1'b1;
                  end
               end
               TACK_STBD: begin
                  if (-cte > maxc) begin
                     tack = TACK_PORT;
                     d.gybe_start = GYBE_TO_PORT;
                     d.boundary_switch = 1'b1;
                  end
               end
               TACK_PORT_RUN: begin
                  if (-cte > maxc) begin
                     tack = TACK_STBD_RUN;
                     d.boundary_switch = 1'b1;
                  end
               end
               default: begin
                  if (cte > maxc) begin
                     tack = TACK_PORT_RUN;
                     d.boundary_switch = 1'b1;
                  end
               end
            endcase
            case (tack)
               TACK_PORT:     raw = hdg + awa + up_lim;
               TACK_STBD:     raw = hdg + awa - up_lim;
               TACK_PORT_RUN: raw = hdg + awa - down_lim + 180;
               default:       raw = hdg + awa + down_lim - 180;
            endcase
         end
         deg = raw % 360;
         if (deg < 0)
            deg += 360;
         d.course_to_steer = 9'(deg);
         d.course_kind     = tack;
         return d;
      endfunction

      function void note_update(req_payload_type u);
         pending_decisions.push_back(decide(u));
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_decision(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_decisions.size() == 0) begin
            errors++;
            $display("%0t: decision with nothing pending, expected none, got course %0d kind %0d",
                     $time, got.course_to_steer, got.course_kind);
            return;
         end
         want = pending_decisions.pop_front();
         compare_field("course_to_steer", want.course_to_steer, got.course_to_steer);
         compare_field("course_kind", want.course_kind, got.course_kind);
         compare_field("gybe_start", want.gybe_start, got.gybe_start);
         compare_field("took_favoured", want.took_favoured, got.took_favoured);
         compare_field("boundary_switch", want.boundary_switch, got.boundary_switch);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // when set, neither side idles
   bit            steady;
   int            quiet_cycles;
   course_checker sb;

   stw_req_if req_if ();
   stw_rsp_if rsp_if ();

   sailing_tack_decision uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // result side: ready drops about one cycle in five unless in the steady stretch
   always @(negedge clock) begin
      rsp_if.ready = (steady || $urandom_range(99) >= 20);
   end

   // every accepted decision is checked against the oldest pending one
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_decision({rsp_if.course_to_steer, rsp_if.course_kind, rsp_if.gybe_start,
                            rsp_if.took_favoured, rsp_if.boundary_switch});
   end

   // watchdog: too long without any transaction ends the run
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
         end
      end
   end

   // one navigation update from literal values, for the directed part
   function automatic req_payload_type nav(int b, int c, int e, int m, int h, int a, int w,
                                           bit hold, bit step);
      req_payload_type u;
      u.bearing_to_waypoint    = 9'(b);
      u.track_correction       = 9'(c);
      u.cross_track_error      = 16'(e);
      u.max_cross_track        = 15'(m);
      u.heading                = 9'(h);
      u.apparent_wind_angle    = 9'(a);
      u.wind_angle_to_waypoint = 9'(w);
      u.boundary_hold          = hold;
      u.new_mission_step       = step;
      return u;
   endfunction

   // random update, biased toward the sailable edges and the cross-track boundary
   function automatic req_payload_type random_update();
      req_payload_type u;
      int maxc, cte, wta, edge_deg;
      u.bearing_to_waypoint = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(359));
      u.heading             = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(359));
      u.track_correction    = ($urandom_range(9) == 0) ? 9'($urandom)
                                                       : 9'(int'($urandom_range(360)) - 180);
      u.apparent_wind_angle = ($urandom_range(9) == 0) ? 9'($urandom)
                                                       : 9'(int'($urandom_range(360)) - 180);

      // mostly short legs so the error straddles the limit on either side
      maxc = ($urandom_range(9) == 0) ? int'($urandom_range(32767)) : int'($urandom_range(300));
      case ($urandom_range(19))
         0, 1:    cte = $signed(16'($urandom));
         2:       cte = ($urandom_range(1) == 0) ? -32768 : 32767;
         default: begin
            cte = maxc + int'($urandom_range(80)) - 40;
            if ($urandom_range(1) == 0)
               cte = -cte;
         end
      endcase
      u.max_cross_track   = 15'(maxc);
      u.cross_track_error = 16'(cte);

      case ($urandom_range(19))
         0, 1: wta = $signed(9'($urandom));
         2, 3, 4, 5, 6, 7: begin
            case ($urandom_range(4))
               0:       edge_deg = sb.up_lim + sb.margin_lim;
               1:       edge_deg = sb.up_lim + sb.margin_lim / 2;
               2:       edge_deg = 180 - sb.down_lim;
               3:       edge_deg = 90;
               default: edge_deg = 0;
            endcase
            wta = edge_deg + int'($urandom_range(6)) - 3;
            if ($urandom_range(1) == 0)
               wta = -wta;
         end
         default: wta = int'($urandom_range(360)) - 180;
      endcase
      u.wind_angle_to_waypoint = 9'(wta);

      // rare new steps and holds so tacks persist across several updates
      u.boundary_hold    = ($urandom_range(99) < 15);
      u.new_mission_step = ($urandom_range(99) < 10);
      return u;
   endfunction

   // drive one update, entered and left at a falling edge
   task automatic send_update(input req_payload_type u);
      if (!steady && $urandom_range(99) < 20) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_if.valid                  = 1'b1;
      req_if.bearing_to_waypoint    = u.bearing_to_waypoint;
      req_if.track_correction       = u.track_correction;
      req_if.cross_track_error      = u.cross_track_error;
      req_if.max_cross_track        = u.max_cross_track;
      req_if.heading                = u.heading;
      req_if.apparent_wind_angle    = u.apparent_wind_angle;
      req_if.wind_angle_to_waypoint = u.wind_angle_to_waypoint;
      req_if.boundary_hold          = u.boundary_hold;
      req_if.new_mission_step       = u.new_mission_step;
      do @(posedge clock); while (!req_if.ready);
      sb.note_update(u);
      @(negedge clock);
   endtask

   // stop sending, wait for every pending decision, then idle on further falling edges
   task automatic drain();
      req_if.valid = 1'b0;
      while (sb.pending_decisions.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // apb write followed by a read back; upper data bits are junk the block must ignore
   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] seen;
      mask        = (idx == REG_SAILABLE_MARGIN) ? 32'h7F : 32'hFF;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = (value & mask) | ($urandom & ~mask);
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if ((seen & mask) !== (value & mask)) begin
         sb.errors++;
         $display("%0t: register %s read back, expected %0d, got %0d",
                  $time, idx.name(), value & mask, seen & mask);
      end
      case (idx)
         REG_MIN_UPWIND:   sb.up_lim     = value & mask;
         REG_MIN_DOWNWIND: sb.down_lim   = value & mask;
         default:          sb.margin_lim = value & mask;
      endcase
   endtask

   // limit settings per phase: defaults, zeros, top of range, full register width, mixes
   int up_set     [PHASE_COUNT] = '{45, 0, 180, 255, 60, 1, 100, 0};
   int down_set   [PHASE_COUNT] = '{30, 0, 180, 255, 45, 90, 10, 0};
   int margin_set [PHASE_COUNT] = '{10, 0, 90, 127, 21, 1, 90, 0};

   initial begin
      sb                            = new();
      reset                         = 1'b1;
      steady                        = 1'b0;
      req_if.valid                  = 1'b0;
      req_if.bearing_to_waypoint    = '0;
      req_if.track_correction       = '0;
      req_if.cross_track_error      = '0;
      req_if.max_cross_track        = '0;
      req_if.heading                = '0;
      req_if.apparent_wind_angle    = '0;
      req_if.wind_angle_to_waypoint = '0;
      req_if.boundary_hold          = 1'b0;
      req_if.new_mission_step       = 1'b0;
      rsp_if.ready                  = 1'b1;
      csr_psel                      = 1'b0;
      csr_penable                   = 1'b0;
      csr_pwrite                    = 1'b0;
      csr_paddr                     = '0;
      csr_pwdata                    = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part under reset limits: sailable when 55 <= |wind to waypoint| <= 150
      // direct course wraps both ways, bearing and correction at and past their range
      send_update(nav(0, 180, 0, 100, 0, 0, 90, 0, 0));
      send_update(nav(359, -180, 0, 100, 0, 0, -90, 0, 0));
      send_update(nav(511, -256, 0, 100, 0, 0, 100, 0, 0));
      send_update(nav(0, 255, 0, 100, 0, 0, -100, 0, 0));
      // port beat favoured from direct, then kept without the favoured flag
      send_update(nav(10, 0, 0, 100, 350, 170, 0, 0, 0));
      send_update(nav(10, 0, 0, 100, 200, -30, 20, 0, 0));
      // beating boundary swaps with gybe starts in both directions
      send_update(nav(10, 0, 101, 100, 200, -30, 20, 0, 0));
      send_update(nav(10, 0, -101, 100, 200, -30, 20, 0, 0));
      // new mission step retakes the favoured tack: port running
      send_update(nav(10, 0, 0, 100, 90, 45, -170, 0, 1));
      // running swaps, no gybe start
      send_update(nav(10, 0, -150, 100, 90, 45, -170, 0, 0));
      send_update(nav(10, 0, 150, 100, 90, 45, -170, 0, 0));
      // favoured starboard running swapped at the boundary in the same step
      send_update(nav(10, 0, 200, 100, 300, 100, 170, 0, 1));
      // sailable at the lower edge goes direct, then a hold forces a tack
      send_update(nav(123, 23, 0, 100, 0, 0, 55, 0, 0));
      send_update(nav(123, 23, 0, 100, 0, 0, 55, 1, 0));
      send_update(nav(123, 23, 0, 100, 0, 0, 50, 0, 0));
      // outside the boundary the margin halves, so 50 becomes sailable
      send_update(nav(123, 23, -32768, 32767, 0, 0, 50, 0, 0));
      // upper sailable edge and one past it
      send_update(nav(200, -100, 0, 100, 0, 0, 150, 0, 0));
      send_update(nav(200, -100, 0, 100, 0, 0, 151, 0, 0));
      send_update(nav(200, -100, 0, 100, 0, 0, -151, 0, 0));
      // field extremes beyond the stated ranges
      send_update(nav(0, 0, 0, 0, 511, -256, -256, 0, 1));
      send_update(nav(0, 0, 32767, 0, 511, 255, 255, 0, 1));
      send_update(nav(0, 0, 32767, 32767, 511, 255, 255, 0, 0));
      send_update(nav(0, 0, 0, 100, 0, -180, -180, 1, 1));
      send_update(nav(0, 0, 0, 100, 359, 180, 180, 1, 1));

      // random phases, each under its own limit settings
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain();
         if (phase == PHASE_COUNT - 1) begin
            up_set[phase]     = $urandom_range(180);
            down_set[phase]   = $urandom_range(180);
            margin_set[phase] = $urandom_range(90);
         end
         write_reg(REG_MIN_UPWIND, up_set[phase]);
         write_reg(REG_MIN_DOWNWIND, down_set[phase]);
         write_reg(REG_SAILABLE_MARGIN, margin_set[phase]);
         // one long stretch at full rate on both sides
         steady = (phase == 1);
         repeat (PHASE_UPDATES) send_update(random_update());
      end
      steady = 1'b0;

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_decisions.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
